### src/hvbd_pkg.sv
`default_nettype none
package hvbd_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned DOTS_PER_BYTE = 7;
	localparam int unsigned PALETTE_BIT   = 7;
	localparam int unsigned COLOR_W       = 3;

	// window: left neighbor, held pixel, seven byte pixels, dark pad
	localparam int unsigned WIN_N = DOTS_PER_BYTE + 3;
	localparam int unsigned CUR_W = $clog2(WIN_N);

	localparam logic [CUR_W-1:0] CUR_HELD      = CUR_W'(1);
	localparam logic [CUR_W-1:0] CUR_BYTE_HEAD = CUR_W'(2);
	localparam logic [CUR_W-1:0] CUR_KEEP_LAST = CUR_W'(DOTS_PER_BYTE);
	localparam logic [CUR_W-1:0] CUR_LINE_LAST = CUR_W'(DOTS_PER_BYTE + 1);

	localparam logic [COLOR_W-1:0] COLOR_BLACK  = 3'd0;
	localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd1;
	localparam logic [COLOR_W-1:0] COLOR_VIOLET = 3'd2;
	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd3;
	localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd4;
	localparam logic [COLOR_W-1:0] COLOR_ORANGE = 3'd5;

	typedef struct packed {
		logic [WIN_N-1:0] dots;
		logic [WIN_N-1:0] pals;
		logic             par_base;
		logic [CUR_W-1:0] cur_start;
		logic             last;
	} work_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               half_dot_even;
		logic               half_dot_odd;
		logic               last_of_run;
		logic               line_done;
	} result_t;

endpackage
`default_nettype wire

### src/hvbd_in_if.sv
`default_nettype none
interface hvbd_in_if;
	logic                          valid;
	logic                          ready;
	logic [hvbd_pkg::BYTE_W-1:0]   video_byte;
	logic                          line_end;

	modport source (output valid, output video_byte, output line_end, input ready);
	modport sink (input valid, input video_byte, input line_end, output ready);
endinterface
`default_nettype wire

### src/hvbd_out_if.sv
`default_nettype none
interface hvbd_out_if;
	logic                          valid;
	logic                          ready;
	logic [hvbd_pkg::COLOR_W-1:0]  pixel_color;
	logic                          half_dot_even;
	logic                          half_dot_odd;
	logic                          last_of_run;
	logic                          line_done;

	modport source (output valid, output pixel_color, output half_dot_even,
		output half_dot_odd, output last_of_run, output line_done, input ready);
	modport sink (input valid, input pixel_color, input half_dot_even,
		input half_dot_odd, input last_of_run, input line_done, output ready);
endinterface
`default_nettype wire

### src/hvbd_line_state.sv
`default_nettype none
module hvbd_line_state (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_wdata,
	input  wire logic                        accept,
	input  wire logic [hvbd_pkg::BYTE_W-1:0] video_byte,
	input  wire logic                        line_end,
	output hvbd_pkg::work_t                  work,
	output logic                             mono
);

	logic mono_q;
	logic pend_dot_q, pend_pal_q, left_dot_q, left_pal_q, parity_q, open_q;
	logic pal;

	assign pal  = video_byte[hvbd_pkg::PALETTE_BIT];
	assign mono = mono_q;

	always_comb begin
		work.dots      = {1'b0, video_byte[hvbd_pkg::DOTS_PER_BYTE-1:0],
			pend_dot_q & open_q, left_dot_q};
		work.pals      = {1'b0, {hvbd_pkg::DOTS_PER_BYTE{pal}},
			pend_pal_q & open_q, left_pal_q};
		work.par_base  = open_q & ~parity_q;
		work.cur_start = open_q ? hvbd_pkg::CUR_HELD : hvbd_pkg::CUR_BYTE_HEAD;
		work.last      = line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
		end else if (cfg_we) begin
			mono_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_dot_q <= 1'b0;
			pend_pal_q <= 1'b0;
			left_dot_q <= 1'b0;
			left_pal_q <= 1'b0;
			parity_q   <= 1'b0;
			open_q     <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				pend_dot_q <= 1'b0;
				pend_pal_q <= 1'b0;
				left_dot_q <= 1'b0;
				left_pal_q <= 1'b0;
				parity_q   <= 1'b0;
				open_q     <= 1'b0;
			end else begin
				pend_dot_q <= video_byte[hvbd_pkg::DOTS_PER_BYTE-1];
				pend_pal_q <= pal;
				left_dot_q <= video_byte[hvbd_pkg::DOTS_PER_BYTE-2];
				left_pal_q <= pal;
				parity_q   <= open_q & ~parity_q;
				open_q     <= 1'b1;
			end
		end
	end

	// held pixel is only nonzero while a line is open
	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (!pend_dot_q && !pend_pal_q && !parity_q))
		else $error("held pixel state not clear between lines");

endmodule
`default_nettype wire

### src/hvbd_pixel_emit.sv
`default_nettype none
module hvbd_pixel_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            mono,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire hvbd_pkg::work_t work,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output hvbd_pkg::result_t    result
);

	hvbd_pkg::work_t             work_s1;
	logic                        work_vld_s1;
	logic [hvbd_pkg::CUR_W-1:0]  cur_s1;
	hvbd_pkg::result_t           res_s2;
	logic                        out_vld_s2;

	logic [hvbd_pkg::CUR_W-1:0]  end_idx, cur_prev, cur_next;
	logic                        fin, load_out, accept;
	logic                        dot, left_dot, right_dot, pal, left_pal, odd_col;
	hvbd_pkg::result_t           res_d;

	assign end_idx  = work_s1.last ? hvbd_pkg::CUR_LINE_LAST : hvbd_pkg::CUR_KEEP_LAST;
	assign fin      = (cur_s1 == end_idx);
	assign load_out = work_vld_s1 && (!out_vld_s2 || out_ready);
	assign in_ready = !work_vld_s1 || (load_out && fin);
	assign accept   = in_valid && in_ready;

	assign cur_prev  = cur_s1 - hvbd_pkg::CUR_W'(1);
	assign cur_next  = cur_s1 + hvbd_pkg::CUR_W'(1);
	assign dot       = work_s1.dots[cur_s1];
	assign left_dot  = work_s1.dots[cur_prev];
	assign right_dot = work_s1.dots[cur_next];
	assign pal       = work_s1.pals[cur_s1];
	assign left_pal  = work_s1.pals[cur_prev];
	assign odd_col   = work_s1.par_base ^ cur_s1[0];

	always_comb begin
		res_d.pixel_color   = hvbd_pkg::COLOR_BLACK;
		res_d.half_dot_even = 1'b0;
		res_d.half_dot_odd  = 1'b0;
		res_d.last_of_run   = fin;
		res_d.line_done     = fin && work_s1.last;
		if (mono) begin
			res_d.half_dot_even = (dot & ~pal) | (left_dot & left_pal);
			res_d.half_dot_odd  = dot;
		end else if (dot) begin
			if (left_dot || right_dot) begin
				res_d.pixel_color = hvbd_pkg::COLOR_WHITE;
			end else begin
				case ({pal, odd_col})
					2'b00:   res_d.pixel_color = hvbd_pkg::COLOR_VIOLET;
					2'b01:   res_d.pixel_color = hvbd_pkg::COLOR_GREEN;
					2'b10:   res_d.pixel_color = hvbd_pkg::COLOR_BLUE;
					default: res_d.pixel_color = hvbd_pkg::COLOR_ORANGE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_vld_s1 <= 1'b0;
			cur_s1      <= hvbd_pkg::CUR_HELD;
		end else if (accept) begin
			work_vld_s1 <= 1'b1;
			cur_s1      <= work.cur_start;
		end else if (load_out) begin
			if (fin) begin
				work_vld_s1 <= 1'b0;
			end else begin
				cur_s1 <= cur_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (load_out) begin
			out_vld_s2 <= 1'b1;
		end else if (out_ready) begin
			out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = out_vld_s2;
	assign result    = res_s2;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> work_vld_s1)
		else $error("accepted byte not held for emission");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_vld_s1 |-> (cur_s1 >= hvbd_pkg::CUR_HELD && cur_s1 <= end_idx))
		else $error("pixel cursor out of range");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_s2 && res_s2.line_done) |-> res_s2.last_of_run)
		else $error("line end not on last pixel of the byte");

	a_color_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s2 |-> (res_s2.pixel_color <= hvbd_pkg::COLOR_ORANGE))
		else $error("illegal color code");

endmodule
`default_nettype wire

### src/hires_video_byte_pixel_decoder.sv
// Hi-res video byte to pixel decoder.
// in_ch carries one video memory byte per transfer (bits 0-6 pixels, least
// significant first, bit 7 palette) with line_end on the last byte of a line.
// out_ch carries one pixel per transfer: artifact color, or two half-dots in
// monochrome mode, with last_of_run on the byte's final pixel and line_done
// on the line's final pixel. cfg_we/cfg_wdata write mono_mode.
// A byte yields seven pixels (six on the first byte of a line, one more on
// the line's last byte), one per cycle from the pixel cursor while out_ch
// does not stall. The next byte is taken in the cycle the current byte's
// final pixel moves into the output register, so bytes stream without gaps.
// A byte's first pixel passes the work register, then the output register.
// Reset clears mono_mode, the held pixel and all valids.
// When out_ch stalls, the output register holds, the cursor stops and
// in_ch.ready drops until the byte in work has drained.
`default_nettype none
module hires_video_byte_pixel_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	hvbd_in_if.sink   in_ch,
	hvbd_out_if.source out_ch
);

	hvbd_pkg::work_t   work;
	hvbd_pkg::result_t result;
	logic              mono;
	logic              accept;

	assign accept = in_ch.valid && in_ch.ready;

	hvbd_line_state u_line_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.video_byte (in_ch.video_byte),
		.line_end   (in_ch.line_end),
		.work       (work),
		.mono       (mono)
	);

	hvbd_pixel_emit u_pixel_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.mono      (mono),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.work      (work),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.result    (result)
	);

	assign out_ch.pixel_color   = result.pixel_color;
	assign out_ch.half_dot_even = result.half_dot_even;
	assign out_ch.half_dot_odd  = result.half_dot_odd;
	assign out_ch.last_of_run   = result.last_of_run;
	assign out_ch.line_done     = result.line_done;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
module tb;

	localparam logic MODE_COLOR = 1'b0;
	localparam logic MODE_MONO  = 1'b1;

	// {pixel_color, half_dot_even, half_dot_odd}
	localparam logic [4:0] PX_BLACK  = {hvbd_pkg::COLOR_BLACK, 2'b00};
	localparam logic [4:0] PX_WHITE  = {hvbd_pkg::COLOR_WHITE, 2'b00};
	localparam logic [4:0] PX_VIOLET = {hvbd_pkg::COLOR_VIOLET, 2'b00};
	localparam logic [4:0] PX_GREEN  = {hvbd_pkg::COLOR_GREEN, 2'b00};
	localparam logic [4:0] PX_BLUE   = {hvbd_pkg::COLOR_BLUE, 2'b00};
	localparam logic [4:0] PX_ORANGE = {hvbd_pkg::COLOR_ORANGE, 2'b00};
	localparam logic [4:0] PX_M00    = {hvbd_pkg::COLOR_BLACK, 2'b00};
	localparam logic [4:0] PX_M01    = {hvbd_pkg::COLOR_BLACK, 2'b01};
	localparam logic [4:0] PX_M11    = {hvbd_pkg::COLOR_BLACK, 2'b11};

	localparam int RANDOM_BYTES = 195;
	localparam int TAIL_START   = 165;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic       mode;
		logic [7:0] vb;
		logic       last;
		logic       typed;
		logic [4:0] fill;
		int         at;
		logic [4:0] spot;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	hvbd_in_if  in_ch();
	hvbd_out_if out_ch();

	hires_video_byte_pixel_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state mirror
	logic mono_q = MODE_COLOR;
	logic held_dot = 1'b0;
	logic held_pal = 1'b0;
	logic left_dot = 1'b0;
	logic left_pal = 1'b0;
	logic col_par = 1'b0;
	logic line_open = 1'b0;

	hvbd_pkg::result_t pixel_q[$];
	int px_errors = 0;
	int bytes_sent = 0;
	int cycles = 0;
	logic quiet = 1'b0;
	logic gaps_on = 1'b0;
	logic stall_rx = 1'b0;

	row_t plan [25] = '{
		'{MODE_COLOR, 8'h00, 1'b1, 1'b1, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h7F, 1'b1, 1'b1, PX_WHITE, 0, PX_WHITE},
		'{MODE_COLOR, 8'hFF, 1'b1, 1'b1, PX_WHITE, 0, PX_WHITE},
		'{MODE_COLOR, 8'h01, 1'b1, 1'b1, PX_BLACK, 0, PX_VIOLET},
		'{MODE_COLOR, 8'h81, 1'b1, 1'b1, PX_BLACK, 0, PX_BLUE},
		'{MODE_COLOR, 8'h02, 1'b1, 1'b1, PX_BLACK, 1, PX_GREEN},
		'{MODE_COLOR, 8'h82, 1'b1, 1'b1, PX_BLACK, 1, PX_ORANGE},
		'{MODE_COLOR, 8'h40, 1'b1, 1'b1, PX_BLACK, 6, PX_VIOLET},
		'{MODE_COLOR, 8'h55, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'hAA, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h2A, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'hD5, 1'b1, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h40, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h01, 1'b1, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h81, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_MONO,  8'h83, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_MONO,  8'h7F, 1'b1, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_MONO,  8'h00, 1'b1, 1'b1, PX_M00, 0, PX_M00},
		'{MODE_MONO,  8'h7F, 1'b1, 1'b1, PX_M11, 0, PX_M11},
		'{MODE_MONO,  8'hFF, 1'b1, 1'b1, PX_M11, 0, PX_M01},
		'{MODE_MONO,  8'h80, 1'b1, 1'b1, PX_M00, 0, PX_M00},
		'{MODE_MONO,  8'hC0, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_MONO,  8'h01, 1'b1, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_MONO,  8'h15, 1'b0, 1'b0, PX_BLACK, 0, PX_BLACK},
		'{MODE_COLOR, 8'h15, 1'b1, 1'b0, PX_BLACK, 0, PX_BLACK}
	};

	function automatic hvbd_pkg::result_t held_pixel(input logic right_dot,
		input logic done);
		hvbd_pkg::result_t r;
		r = '0;
		if (mono_q == MODE_MONO) begin
			r.half_dot_even = (held_dot & ~held_pal) | (left_dot & left_pal);
			r.half_dot_odd = held_dot;
		end else if (held_dot) begin
			if (left_dot || right_dot)
				r.pixel_color = hvbd_pkg::COLOR_WHITE;
			else if (held_pal)
				r.pixel_color = col_par ? hvbd_pkg::COLOR_ORANGE : hvbd_pkg::COLOR_BLUE;
			else
				r.pixel_color = col_par ? hvbd_pkg::COLOR_GREEN : hvbd_pkg::COLOR_VIOLET;
		end
		r.line_done = done;
		return r;
	endfunction

	task automatic decode_byte(input logic [7:0] vb, input logic last, input logic typed,
		input logic [4:0] fill, input int at, input logic [4:0] spot);
		hvbd_pkg::result_t run [0:7];
		logic [4:0] v;
		int n;
		int i;
		n = 0;
		for (i = 0; i < hvbd_pkg::DOTS_PER_BYTE; i++) begin
			if (line_open) begin
				run[n] = held_pixel(vb[i], 1'b0);
				n++;
				left_dot = held_dot;
				left_pal = held_pal;
				col_par = ~col_par;
			end else begin
				left_dot = 1'b0;
				left_pal = 1'b0;
				col_par = 1'b0;
			end
			held_dot = vb[i];
			held_pal = vb[hvbd_pkg::PALETTE_BIT];
			line_open = 1'b1;
		end
		if (last) begin
			run[n] = held_pixel(1'b0, 1'b1);
			n++;
			line_open = 1'b0;
			held_dot = 1'b0;
			held_pal = 1'b0;
			left_dot = 1'b0;
			left_pal = 1'b0;
			col_par = 1'b0;
		end
		run[n-1].last_of_run = 1'b1;
		for (i = 0; i < n; i++) begin
			if (typed) begin
				v = (i == at) ? spot : fill;
				run[i].pixel_color = v[4:2];
				run[i].half_dot_even = v[1];
				run[i].half_dot_odd = v[0];
			end
			pixel_q.push_back(run[i]);
		end
	endtask

	task automatic push_byte(input logic [7:0] vb, input logic last, input logic typed,
		input logic [4:0] fill, input int at, input logic [4:0] spot);
		int gap;
		if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			repeat (gap) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.video_byte <= vb;
		in_ch.line_end <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		decode_byte(vb, last, typed, fill, at, spot);
		bytes_sent++;
	endtask

	// write mono_mode once every pixel in flight has drained
	task automatic set_mode(input logic m);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		mono_q = m;
	endtask

	function automatic logic [7:0] rand_byte();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: b = 8'($urandom_range(0, 255));
			1: b = {1'($urandom_range(0, 1)), 7'(1 << $urandom_range(0, 6))};
			2: b = 8'($urandom_range(0, 255)) & ($urandom_range(0, 1) ? 8'hD5 : 8'hAA);
			default: begin
				case ($urandom_range(0, 3))
					0: b = 8'h00;
					1: b = 8'h7F;
					2: b = 8'hFF;
					default: b = 8'h80;
				endcase
			end
		endcase
		return b;
	endfunction

	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && stall_rx && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		hvbd_pkg::result_t want;
		hvbd_pkg::result_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.pixel_color = out_ch.pixel_color;
			got.half_dot_even = out_ch.half_dot_even;
			got.half_dot_odd = out_ch.half_dot_odd;
			got.last_of_run = out_ch.last_of_run;
			got.line_done = out_ch.line_done;
			if (pixel_q.size() == 0) begin
				px_errors++;
				if (px_errors <= 10)
					$display("unexpected pixel transfer: %p", got);
			end else begin
				want = pixel_q.pop_front();
				if (got.pixel_color !== want.pixel_color
						|| got.half_dot_even !== want.half_dot_even
						|| got.half_dot_odd !== want.half_dot_odd
						|| got.last_of_run !== want.last_of_run
						|| got.line_done !== want.line_done) begin
					px_errors++;
					if (px_errors <= 10)
						$display("pixel mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("hires_video_byte_pixel_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		int r;
		int k;
		int len;
		int pick;
		in_ch.valid = 1'b0;
		in_ch.video_byte = '0;
		in_ch.line_end = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_mode(MODE_COLOR);
		for (r = 0; r < 25; r++) begin
			gaps_on = r[0];
			stall_rx = r[1];
			if (plan[r].mode != mono_q)
				set_mode(plan[r].mode);
			push_byte(plan[r].vb, plan[r].last, plan[r].typed, plan[r].fill, plan[r].at,
				plan[r].spot);
		end

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= TAIL_START)
				quiet = 1'b1;
			if (!quiet && $urandom_range(0, 4) == 0)
				set_mode(1'($urandom_range(0, 1)));
			pick = $urandom_range(0, 9);
			len = (pick == 0) ? 45 : (pick < 3) ? 1 : $urandom_range(2, 6);
			if (len > RANDOM_BYTES - bytes_sent)
				len = RANDOM_BYTES - bytes_sent;
			gaps_on = $urandom_range(0, 2) != 0;
			stall_rx = $urandom_range(0, 2) != 0;
			for (k = 0; k < len; k++) begin
				if (!quiet && k != 0 && $urandom_range(0, 24) == 0)
					set_mode(~mono_q);
				push_byte(rand_byte(), k == len - 1, 1'b0, PX_BLACK, 0, PX_BLACK);
			end
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (px_errors == 0)
			$display("hires_video_byte_pixel_decoder regression: pass");
		else
			$display("hires_video_byte_pixel_decoder regression: fail");
		$finish;
	end
endmodule
